// ----- sv/min_cost_flow_solver_core_defines.svh -----
// assertion helpers shared by the core
`ifndef MIN_COST_FLOW_SOLVER_CORE_DEFINES_SVH
`define MIN_COST_FLOW_SOLVER_CORE_DEFINES_SVH

// same-cycle implication
`define MCFS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MCFS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/mcfs_pkg.sv -----
package mcfs_pkg;

  localparam int unsigned MAX_VERTICES = 64;
  localparam int unsigned MAX_EDGES    = 256;
  localparam int unsigned MAX_ARCS     = 2 * MAX_EDGES;

  localparam int unsigned VIDX = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned VCW  = $clog2(MAX_VERTICES + 1);
  localparam int unsigned EIDX = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned ECW  = $clog2(MAX_EDGES + 1);
  localparam int unsigned AIDX = EIDX + 1;
  localparam int unsigned ACW  = AIDX + 1;

  localparam int unsigned DW    = 48;
  localparam int unsigned HTW   = DW - 1;
  localparam int unsigned HT_LO = 32;
  localparam int unsigned HT_HI = HTW - HT_LO;

  localparam logic [61:0] COST_MAX = {62{1'b1}};

  typedef struct packed {
    logic [5:0]  edge_from;
    logic [5:0]  edge_to;
    logic [31:0] edge_capacity;
    logic [30:0] edge_cost;
    logic        last_edge;
  } edge_in_t;

  typedef struct packed {
    logic [61:0] total_cost;
    logic        infeasible;
  } result_t;

  typedef struct packed {
    logic [6:0]  vertex_count;
    logic [5:0]  source_vertex;
    logic [5:0]  sink_vertex;
    logic [31:0] flow_demand;
  } cfg_t;

  typedef struct packed {
    logic [5:0]  from_v;
    logic [5:0]  to_v;
    logic [30:0] cost;
    logic [31:0] res_f;
    logic [31:0] res_r;
  } edge_word_t;

  typedef enum logic [1:0] {
    REG_VERTEX_COUNT = 2'd0,
    REG_SOURCE       = 2'd1,
    REG_SINK         = 2'd2,
    REG_DEMAND       = 2'd3
  } reg_idx_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_SETUP,
    OP_POT_CLR,
    OP_SP_INIT,
    OP_SCAN_INIT,
    OP_SCAN_RD,
    OP_SCAN_CMP,
    OP_SEL,
    OP_SEL_POT,
    OP_ARC_RD,
    OP_ARC_CHK,
    OP_ARC_SUM,
    OP_ARC_UPD,
    OP_IDX_CLR,
    OP_POT_RD,
    OP_POT_WR,
    OP_WALK_INIT,
    OP_WALK_REW,
    OP_PRED_RD,
    OP_EDGE_RD,
    OP_WALK_MIN,
    OP_WALK_PUSH,
    OP_HT_RD,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_ACC_PROD,
    OP_ACC_SUM,
    OP_FINISH_OK,
    OP_FINISH_FAIL
  } op_e;

  typedef struct packed {
    logic solve_start;
    logic i_end;
    logic a_end;
    logic found;
    logic arc_ok;
    logic walk_done;
    logic f_zero;
    logic bad_ends;
    logic t_reached;
    logic out_busy;
  } stat_t;

endpackage

// ----- sv/mcfs_if.sv -----
interface mcfs_edge_if import mcfs_pkg::*; ();
  logic     valid;
  logic     ready;
  edge_in_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface mcfs_result_if import mcfs_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- sv/mcfs_ram.sv -----
module mcfs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/mcfs_dp.sv -----
module mcfs_dp import mcfs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  op_e      cmd_i,
  input  cfg_t     cfg_i,
  input  logic     load_i,
  input  edge_in_t edge_i,
  output stat_t    stat_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output result_t  out_o
);

  localparam int unsigned EWW = $bits(edge_word_t);

  // control state
  logic [ECW-1:0]          edge_cnt_q;
  logic                    out_valid_q;
  logic [MAX_VERTICES-1:0] reached_q, settled_q;
  logic                    found_q;

  // working registers
  logic [VCW-1:0]        n_q, i_q, steps_q;
  logic [ACW-1:0]        a_q;
  logic [AIDX-1:0]       arc_q;
  logic signed [DW-1:0]  best_q, dvp_q, t1_q;
  logic [VIDX-1:0]       v_q, head_q, vw_q;
  logic signed [32:0]    cost_q;
  logic [31:0]           d_q, f_q;
  logic [61:0]           res_q, add_q;
  logic [HT_HI-1:0]      ht_hi_q;
  logic [63:0]           p_lo_q;
  logic [HT_HI+31:0]     p_hi_q;
  result_t               out_q;

  // held read addresses
  logic [EIDX-1:0] er_q, er_d;
  logic [VIDX-1:0] dr_q, dr_d, pr_q, pr_d, qr_q, qr_d;

  // ram ports
  logic            e_we, d_we, p_we, q_we;
  logic [EIDX-1:0] e_wa;
  logic [VIDX-1:0] d_wa, p_wa, q_wa;
  logic [EWW-1:0]  e_wd, e_rd;
  logic [DW-1:0]   d_wd, p_wd, d_rd, p_rd;
  logic [AIDX-1:0] q_wd, q_rd;

  edge_word_t ew, ew_new;
  logic [VIDX-1:0] s_v, t_v, idx;
  logic [VCW-1:0]  n_c;

  // scan decode
  logic [5:0]  tail_s, head_s;
  logic [31:0] res_s;
  logic signed [32:0] cost_s;
  logic arc_ok;

  // walk decode
  logic [5:0]  tail_w;
  logic [31:0] res_w;

  logic signed [DW-1:0] d_rs, p_rs, nd;
  logic                 upd, cand, load_ok;
  logic [HTW-1:0]       ht;
  logic [HT_HI+63:0]    prod;
  logic [62:0]          sum;

  assign ew  = edge_word_t'(e_rd);
  assign s_v = VIDX'(cfg_i.source_vertex);
  assign t_v = VIDX'(cfg_i.sink_vertex);
  assign idx = i_q[VIDX-1:0];
  assign d_rs = $signed(d_rd);
  assign p_rs = $signed(p_rd);

  always_comb begin
    if (cfg_i.vertex_count == 7'd0) begin
      n_c = VCW'(1);
    end else if (cfg_i.vertex_count > MAX_VERTICES) begin
      n_c = VCW'(MAX_VERTICES);
    end else begin
      n_c = VCW'(cfg_i.vertex_count);
    end
  end

  assign tail_s = a_q[0] ? ew.to_v : ew.from_v;
  assign head_s = a_q[0] ? ew.from_v : ew.to_v;
  assign res_s  = a_q[0] ? ew.res_r : ew.res_f;
  assign cost_s = a_q[0] ? -$signed({2'b00, ew.cost}) : $signed({2'b00, ew.cost});
  assign arc_ok = (VIDX'(tail_s) == v_q) && (res_s != 32'd0) && (head_s < n_q) &&
                  !settled_q[VIDX'(head_s)];

  assign tail_w = arc_q[0] ? ew.to_v : ew.from_v;
  assign res_w  = arc_q[0] ? ew.res_r : ew.res_f;

  assign nd   = t1_q - p_rs;
  assign upd  = !reached_q[head_q] || (nd < d_rs);
  assign cand = reached_q[idx] && !settled_q[idx] && (!found_q || (d_rs < best_q));
  assign ht   = (p_rs > 0) ? p_rd[HTW-1:0] : '0;
  assign prod = {p_hi_q, 32'd0} + {{HT_HI{1'b0}}, p_lo_q};
  assign sum  = {1'b0, res_q} + {1'b0, add_q};
  assign load_ok = load_i && (edge_i.edge_from < MAX_VERTICES) &&
                   (edge_i.edge_to < MAX_VERTICES) && (edge_cnt_q < MAX_EDGES);

  always_comb begin
    ew_new = ew;
    if (arc_q[0]) begin
      ew_new.res_r = ew.res_r - d_q;
      ew_new.res_f = ew.res_f + d_q;
    end else begin
      ew_new.res_f = ew.res_f - d_q;
      ew_new.res_r = ew.res_r + d_q;
    end
  end

  // ram control
  always_comb begin
    er_d = er_q;
    dr_d = dr_q;
    pr_d = pr_q;
    qr_d = qr_q;
    e_we = 1'b0;
    e_wa = edge_cnt_q[EIDX-1:0];
    e_wd = EWW'({edge_i.edge_from, edge_i.edge_to, edge_i.edge_cost,
                 edge_i.edge_capacity, 32'd0});
    d_we = 1'b0;
    d_wa = head_q;
    d_wd = nd;
    p_we = 1'b0;
    p_wa = idx;
    p_wd = '0;
    q_we = 1'b0;
    q_wa = head_q;
    q_wd = arc_q;
    if (load_ok) begin
      e_we = 1'b1;
    end
    case (cmd_i)
      OP_POT_CLR: p_we = (i_q != n_q);
      OP_SP_INIT: begin
        d_we = 1'b1;
        d_wa = s_v;
        d_wd = '0;
      end
      OP_SCAN_RD: dr_d = idx;
      OP_SEL:     pr_d = v_q;
      OP_ARC_RD:  er_d = a_q[AIDX-1:1];
      OP_ARC_CHK: begin
        dr_d = VIDX'(head_s);
        pr_d = VIDX'(head_s);
      end
      OP_ARC_UPD: begin
        d_we = upd;
        q_we = upd;
      end
      OP_POT_RD: begin
        dr_d = idx;
        pr_d = idx;
      end
      OP_POT_WR: begin
        p_we = reached_q[idx];
        p_wd = p_rd + d_rd;
      end
      OP_PRED_RD: qr_d = vw_q;
      OP_EDGE_RD: er_d = q_rd[AIDX-1:1];
      OP_WALK_PUSH: begin
        e_we = 1'b1;
        e_wa = arc_q[AIDX-1:1];
        e_wd = EWW'(ew_new);
      end
      OP_HT_RD: pr_d = t_v;
      default: ;
    endcase
  end

  mcfs_ram #(.WIDTH(EWW), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk_i(clk_i), .we_i(e_we), .waddr_i(e_wa), .wdata_i(e_wd),
    .raddr_i(er_d), .rdata_o(e_rd)
  );

  mcfs_ram #(.WIDTH(DW), .DEPTH(MAX_VERTICES)) u_dist_ram (
    .clk_i(clk_i), .we_i(d_we), .waddr_i(d_wa), .wdata_i(d_wd),
    .raddr_i(dr_d), .rdata_o(d_rd)
  );

  mcfs_ram #(.WIDTH(DW), .DEPTH(MAX_VERTICES)) u_pot_ram (
    .clk_i(clk_i), .we_i(p_we), .waddr_i(p_wa), .wdata_i(p_wd),
    .raddr_i(pr_d), .rdata_o(p_rd)
  );

  mcfs_ram #(.WIDTH(AIDX), .DEPTH(MAX_VERTICES)) u_pred_ram (
    .clk_i(clk_i), .we_i(q_we), .waddr_i(q_wa), .wdata_i(q_wd),
    .raddr_i(qr_d), .rdata_o(q_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_cnt_q  <= '0;
      out_valid_q <= 1'b0;
      reached_q   <= '0;
      settled_q   <= '0;
      found_q     <= 1'b0;
    end else begin
      if (load_ok) begin
        edge_cnt_q <= edge_cnt_q + ECW'(1);
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i)
        OP_SP_INIT: begin
          reached_q <= {{(MAX_VERTICES-1){1'b0}}, 1'b1} << s_v;
          settled_q <= '0;
          found_q   <= 1'b0;
        end
        OP_SCAN_INIT: found_q <= 1'b0;
        OP_SCAN_CMP:  if (cand) found_q <= 1'b1;
        OP_SEL:       settled_q[v_q] <= 1'b1;
        OP_ARC_UPD:   if (upd) reached_q[head_q] <= 1'b1;
        OP_FINISH_OK, OP_FINISH_FAIL: begin
          out_valid_q <= 1'b1;
          edge_cnt_q  <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    er_q <= er_d;
    dr_q <= dr_d;
    pr_q <= pr_d;
    qr_q <= qr_d;
    case (cmd_i)
      OP_SETUP: begin
        n_q   <= n_c;
        i_q   <= '0;
        f_q   <= cfg_i.flow_demand;
        res_q <= '0;
      end
      OP_POT_CLR:   if (i_q != n_q) i_q <= i_q + VCW'(1);
      OP_SP_INIT, OP_SCAN_INIT, OP_IDX_CLR: i_q <= '0;
      OP_SCAN_CMP: begin
        if (cand) begin
          best_q <= d_rs;
          v_q    <= idx;
        end
        i_q <= i_q + VCW'(1);
      end
      OP_SEL:     a_q <= '0;
      OP_SEL_POT: dvp_q <= best_q + p_rs;
      OP_ARC_CHK: begin
        arc_q  <= a_q[AIDX-1:0];
        a_q    <= a_q + ACW'(1);
        head_q <= VIDX'(head_s);
        cost_q <= cost_s;
      end
      OP_ARC_SUM: t1_q <= dvp_q + {{(DW-33){cost_q[32]}}, cost_q};
      OP_POT_WR:  i_q <= i_q + VCW'(1);
      OP_WALK_INIT: begin
        vw_q    <= t_v;
        steps_q <= '0;
        d_q     <= f_q;
      end
      OP_WALK_REW: begin
        vw_q    <= t_v;
        steps_q <= '0;
      end
      OP_EDGE_RD: arc_q <= q_rd;
      OP_WALK_MIN: begin
        if (res_w < d_q) d_q <= res_w;
        vw_q    <= VIDX'(tail_w);
        steps_q <= steps_q + VCW'(1);
      end
      OP_WALK_PUSH: begin
        vw_q    <= VIDX'(tail_w);
        steps_q <= steps_q + VCW'(1);
      end
      OP_MUL_LO: begin
        p_lo_q  <= d_q * ht[HT_LO-1:0];
        ht_hi_q <= ht[HTW-1:HT_LO];
      end
      OP_MUL_HI:   p_hi_q <= d_q * ht_hi_q;
      OP_ACC_PROD: add_q <= (prod > {{(HT_HI+2){1'b0}}, COST_MAX}) ? COST_MAX : prod[61:0];
      OP_ACC_SUM: begin
        res_q <= sum[62] ? COST_MAX : sum[61:0];
        f_q   <= f_q - d_q;
      end
      OP_FINISH_OK: begin
        out_q.total_cost <= res_q;
        out_q.infeasible <= 1'b0;
      end
      OP_FINISH_FAIL: begin
        out_q.total_cost <= '0;
        out_q.infeasible <= 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    stat_o.solve_start = load_i && edge_i.last_edge;
    stat_o.i_end       = (i_q == n_q);
    stat_o.a_end       = (a_q == ACW'({edge_cnt_q, 1'b0}));
    stat_o.found       = found_q;
    stat_o.arc_ok      = arc_ok;
    stat_o.walk_done   = (vw_q == s_v) || (steps_q >= n_q);
    stat_o.f_zero      = (f_q == 32'd0);
    stat_o.bad_ends    = (cfg_i.source_vertex >= n_q) || (cfg_i.sink_vertex >= n_q);
    stat_o.t_reached   = reached_q[t_v];
    stat_o.out_busy    = out_valid_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ----- sv/mcfs_ctrl.sv -----
module mcfs_ctrl import mcfs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  stat_t stat_i,
  output op_e   cmd_o,
  output logic  in_ready_o
);

  typedef enum logic [5:0] {
    S_IDLE, S_SETUP, S_CHECK, S_POT_CLR, S_SP_INIT, S_SCAN_INIT, S_SCAN_RD, S_SCAN_CMP,
    S_SEL, S_SEL_POT, S_ARC_RD, S_ARC_CHK, S_ARC_SUM, S_ARC_UPD, S_POST, S_IDX_CLR,
    S_POT_RD, S_POT_WR, S_WALK_INIT, S_PRED1, S_EDGE1, S_WALK_MIN, S_WALK_REW, S_PRED2,
    S_EDGE2, S_WALK_PUSH, S_HT_RD, S_MUL_LO, S_MUL_HI, S_ACC_PROD, S_ACC_SUM, S_LOOP,
    S_OK_WAIT, S_OK, S_FAIL_WAIT, S_FAIL
  } state_e;

  state_e state_q, state_d;
  op_e    cmd_q;
  logic   in_ready_q;

  function automatic op_e op_of(state_e s);
    case (s)
      S_SETUP:     return OP_SETUP;
      S_POT_CLR:   return OP_POT_CLR;
      S_SP_INIT:   return OP_SP_INIT;
      S_SCAN_INIT: return OP_SCAN_INIT;
      S_SCAN_RD:   return OP_SCAN_RD;
      S_SCAN_CMP:  return OP_SCAN_CMP;
      S_SEL:       return OP_SEL;
      S_SEL_POT:   return OP_SEL_POT;
      S_ARC_RD:    return OP_ARC_RD;
      S_ARC_CHK:   return OP_ARC_CHK;
      S_ARC_SUM:   return OP_ARC_SUM;
      S_ARC_UPD:   return OP_ARC_UPD;
      S_IDX_CLR:   return OP_IDX_CLR;
      S_POT_RD:    return OP_POT_RD;
      S_POT_WR:    return OP_POT_WR;
      S_WALK_INIT: return OP_WALK_INIT;
      S_WALK_REW:  return OP_WALK_REW;
      S_PRED1, S_PRED2: return OP_PRED_RD;
      S_EDGE1, S_EDGE2: return OP_EDGE_RD;
      S_WALK_MIN:  return OP_WALK_MIN;
      S_WALK_PUSH: return OP_WALK_PUSH;
      S_HT_RD:     return OP_HT_RD;
      S_MUL_LO:    return OP_MUL_LO;
      S_MUL_HI:    return OP_MUL_HI;
      S_ACC_PROD:  return OP_ACC_PROD;
      S_ACC_SUM:   return OP_ACC_SUM;
      S_OK:        return OP_FINISH_OK;
      S_FAIL:      return OP_FINISH_FAIL;
      default:     return OP_NONE;
    endcase
  endfunction

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:      if (stat_i.solve_start) state_d = S_SETUP;
      S_SETUP:     state_d = S_CHECK;
      S_CHECK: begin
        if (stat_i.f_zero) state_d = S_OK_WAIT;
        else if (stat_i.bad_ends) state_d = S_FAIL_WAIT;
        else state_d = S_POT_CLR;
      end
      S_POT_CLR:   if (stat_i.i_end) state_d = S_SP_INIT;
      S_SP_INIT:   state_d = S_SCAN_RD;
      S_SCAN_INIT: state_d = S_SCAN_RD;
      S_SCAN_RD: begin
        if (!stat_i.i_end) state_d = S_SCAN_CMP;
        else if (stat_i.found) state_d = S_SEL;
        else state_d = S_POST;
      end
      S_SCAN_CMP:  state_d = S_SCAN_RD;
      S_SEL:       state_d = S_SEL_POT;
      S_SEL_POT:   state_d = S_ARC_RD;
      S_ARC_RD:    state_d = stat_i.a_end ? S_SCAN_INIT : S_ARC_CHK;
      S_ARC_CHK:   state_d = stat_i.arc_ok ? S_ARC_SUM : S_ARC_RD;
      S_ARC_SUM:   state_d = S_ARC_UPD;
      S_ARC_UPD:   state_d = S_ARC_RD;
      S_POST:      state_d = stat_i.t_reached ? S_IDX_CLR : S_FAIL_WAIT;
      S_IDX_CLR:   state_d = S_POT_RD;
      S_POT_RD:    state_d = stat_i.i_end ? S_WALK_INIT : S_POT_WR;
      S_POT_WR:    state_d = S_POT_RD;
      S_WALK_INIT: state_d = S_PRED1;
      S_PRED1:     state_d = stat_i.walk_done ? S_WALK_REW : S_EDGE1;
      S_EDGE1:     state_d = S_WALK_MIN;
      S_WALK_MIN:  state_d = S_PRED1;
      S_WALK_REW:  state_d = S_PRED2;
      S_PRED2:     state_d = stat_i.walk_done ? S_HT_RD : S_EDGE2;
      S_EDGE2:     state_d = S_WALK_PUSH;
      S_WALK_PUSH: state_d = S_PRED2;
      S_HT_RD:     state_d = S_MUL_LO;
      S_MUL_LO:    state_d = S_MUL_HI;
      S_MUL_HI:    state_d = S_ACC_PROD;
      S_ACC_PROD:  state_d = S_ACC_SUM;
      S_ACC_SUM:   state_d = S_LOOP;
      S_LOOP:      state_d = stat_i.f_zero ? S_OK_WAIT : S_SP_INIT;
      S_OK_WAIT:   if (!stat_i.out_busy) state_d = S_OK;
      S_OK:        state_d = S_IDLE;
      S_FAIL_WAIT: if (!stat_i.out_busy) state_d = S_FAIL;
      S_FAIL:      state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cmd_q      <= OP_NONE;
      in_ready_q <= 1'b1;
    end else begin
      state_q    <= state_d;
      cmd_q      <= op_of(state_d);
      in_ready_q <= (state_d == S_IDLE);
    end
  end

  assign cmd_o      = cmd_q;
  assign in_ready_o = in_ready_q;

endmodule

// ----- sv/min_cost_flow_solver_core.sv -----
// min-cost flow core, successive shortest paths with vertex potentials
// edge_in: one directed edge per transaction; while idle one edge is taken
//   every cycle and, while the table has room, stored with its reverse residual arc
// the edge flagged last_edge starts a solve; edge_in stays not ready until done
// solve: each augmenting round scans the distance array and the arc table once
//   per settled vertex through registered-read arc and vertex memories, then
//   updates the vertex potentials and walks the path twice
// result_out: one transaction per solve, total cost saturating at 2^62-1, or
//   infeasible with cost zero; the edge table is then empty again
// a stalled result holds in its output register; the next edges are taken,
//   and a following solve only waits before posting its own result
// reset: edge table empty, registers at their defaults, no result pending
// registers over apb at byte offsets 0, 4, 8, 12; write only while idle
`include "min_cost_flow_solver_core_defines.svh"

module min_cost_flow_solver_core import mcfs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  mcfs_edge_if.sink   edge_in,
  mcfs_result_if.source result_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t  cfg_q;
  stat_t stat;
  op_e   cmd;
  logic  in_ready, edge_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vertex_count  <= 7'd64;
      cfg_q.source_vertex <= 6'd0;
      cfg_q.sink_vertex   <= 6'd63;
      cfg_q.flow_demand   <= 32'd0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx_e'(paddr[3:2]))
        REG_VERTEX_COUNT: cfg_q.vertex_count  <= pwdata[6:0];
        REG_SOURCE:       cfg_q.source_vertex <= pwdata[5:0];
        REG_SINK:         cfg_q.sink_vertex   <= pwdata[5:0];
        REG_DEMAND:       cfg_q.flow_demand   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[3:2]))
      REG_VERTEX_COUNT: prdata = {25'd0, cfg_q.vertex_count};
      REG_SOURCE:       prdata = {26'd0, cfg_q.source_vertex};
      REG_SINK:         prdata = {26'd0, cfg_q.sink_vertex};
      REG_DEMAND:       prdata = cfg_q.flow_demand;
      default:          prdata = 32'd0;
    endcase
  end

  assign pready        = 1'b1;
  assign edge_fire     = edge_in.valid && in_ready;
  assign edge_in.ready = in_ready;

  mcfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_ready_o (in_ready)
  );

  mcfs_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_i       (cfg_q),
    .load_i      (edge_fire),
    .edge_i      (edge_in.payload),
    .stat_o      (stat),
    .out_valid_o (result_out.valid),
    .out_ready_i (result_out.ready),
    .out_o       (result_out.payload)
  );

  `MCFS_ASSERT_IMP(a_ready_only_idle, clk_i, rst_ni, edge_in.ready,
                   cmd == OP_NONE, "edge input open during a solve")
  `MCFS_ASSERT_IMP(a_no_overwrite, clk_i, rst_ni,
                   cmd == OP_FINISH_OK || cmd == OP_FINISH_FAIL,
                   !result_out.valid, "result posted over a pending one")
  `MCFS_ASSERT_IMP(a_fail_zero_cost, clk_i, rst_ni,
                   result_out.valid && result_out.payload.infeasible,
                   result_out.payload.total_cost == 62'd0, "infeasible result with cost")
  `MCFS_ASSERT_NXT(a_finish_posts, clk_i, rst_ni,
                   cmd == OP_FINISH_OK || cmd == OP_FINISH_FAIL,
                   result_out.valid && edge_in.ready,
                   "finish did not post result and reopen input")

endmodule

// ----- verif/tb_min_cost_flow_solver_core.sv -----
module tb_min_cost_flow_solver_core;
  import mcfs_pkg::*;

  localparam longint unsigned CYCLE_LIMIT = 20_000_000;
  localparam int unsigned ITEM_TARGET = 1500;

  class flow_scoreboard;
    bit [5:0]        arc_from [MAX_ARCS];
    bit [5:0]        arc_to [MAX_ARCS];
    longint          arc_price [MAX_ARCS];
    longint unsigned arc_left [MAX_ARCS];
    int unsigned     arcs_used;
    longint          potential [MAX_VERTICES];
    longint          distance [MAX_VERTICES];
    bit              settled [MAX_VERTICES];
    bit              reached [MAX_VERTICES];
    int unsigned     pred [MAX_VERTICES];
    cfg_t            cfg;
    result_t         pending_results [$];
    int unsigned     fails;

    function new();
      arcs_used = 0;
      fails = 0;
      cfg.vertex_count = 7'd64;
      cfg.source_vertex = 6'd0;
      cfg.sink_vertex = 6'd63;
      cfg.flow_demand = 32'd0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [31:0] v);
      case (idx)
        REG_VERTEX_COUNT: cfg.vertex_count = v[6:0];
        REG_SOURCE:       cfg.source_vertex = v[5:0];
        REG_SINK:         cfg.sink_vertex = v[5:0];
        REG_DEMAND:       cfg.flow_demand = v;
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void dijkstra(int unsigned n, int unsigned s);
      int unsigned v;
      int unsigned h;
      longint nd;
      for (int unsigned i = 0; i < n; i++) begin
        reached[i] = 0;
        settled[i] = 0;
        distance[i] = 0;
        pred[i] = 0;
      end
      reached[s] = 1;
      for (int unsigned r = 0; r < n; r++) begin
        v = n;
        for (int unsigned i = 0; i < n; i++)
          if (reached[i] && !settled[i] && (v == n || distance[i] < distance[v]))
            v = i;
        if (v == n) break;
        settled[v] = 1;
        for (int unsigned a = 0; a < arcs_used; a++) begin
          if (arc_from[a] != v || arc_left[a] == 0) continue;
          h = arc_to[a];
          if (h >= n || settled[h]) continue;
          nd = distance[v] + arc_price[a] + potential[v] - potential[h];
          if (!reached[h] || nd < distance[h]) begin
            reached[h] = 1;
            distance[h] = nd;
            pred[h] = a;
          end
        end
      end
    endfunction

    function result_t min_cost();
      result_t         r;
      int unsigned     n;
      int unsigned     s;
      int unsigned     t;
      int unsigned     v;
      int unsigned     a;
      longint unsigned f;
      longint unsigned acc;
      longint unsigned d;
      longint unsigned ht;
      longint unsigned add;
      longint unsigned cmax;
      cmax = {2'b00, COST_MAX};
      n = cfg.vertex_count;
      s = cfg.source_vertex;
      t = cfg.sink_vertex;
      f = cfg.flow_demand;
      acc = 0;
      r = '0;
      if (n == 0) n = 1;
      if (n > MAX_VERTICES) n = MAX_VERTICES;
      if (f == 0) return r;
      if (s >= n || t >= n) begin
        r.infeasible = 1'b1;
        return r;
      end
      for (int unsigned i = 0; i < n; i++) potential[i] = 0;
      while (f > 0) begin
        d = f;
        dijkstra(n, s);
        if (!reached[t]) begin
          r.infeasible = 1'b1;
          return r;
        end
        for (int unsigned i = 0; i < n; i++)
          if (reached[i]) potential[i] += distance[i];
        v = t;
        for (int unsigned k = 0; v != s && k < n; k++) begin
          a = pred[v];
          if (arc_left[a] < d) d = arc_left[a];
          v = arc_from[a];
        end
        v = t;
        for (int unsigned k = 0; v != s && k < n; k++) begin
          a = pred[v];
          arc_left[a] -= d;
          arc_left[a ^ 1] += d;
          v = arc_from[a];
        end
        f -= d;
        ht = (potential[t] > 0) ? longint'(potential[t]) : 0;
        if (ht != 0 && d > cmax / ht) add = cmax;
        else add = d * ht;
        acc = (add > cmax - acc) ? cmax : acc + add;
      end
      r.total_cost = acc[61:0];
      return r;
    endfunction

    function void note_edge(edge_in_t e);
      if (arcs_used + 2 <= MAX_ARCS) begin
        arc_from[arcs_used] = e.edge_from;
        arc_to[arcs_used] = e.edge_to;
        arc_price[arcs_used] = longint'(e.edge_cost);
        arc_left[arcs_used] = e.edge_capacity;
        arc_from[arcs_used + 1] = e.edge_to;
        arc_to[arcs_used + 1] = e.edge_from;
        arc_price[arcs_used + 1] = -longint'(e.edge_cost);
        arc_left[arcs_used + 1] = 0;
        arcs_used += 2;
      end
      if (e.last_edge) begin
        pending_results.insert(pending_results.size(), min_cost());
        arcs_used = 0;
      end
    endfunction

    function void check_result(result_t got);
      result_t exp_r;
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result cost %h infeasible %b", $time,
                 got.total_cost, got.infeasible);
        fails++;
        return;
      end
      exp_r = pending_results.pop_front();
      if (got.total_cost !== exp_r.total_cost) begin
        $display("%0t total_cost expected %h actual %h", $time,
                 exp_r.total_cost, got.total_cost);
        fails++;
      end
      if (got.infeasible !== exp_r.infeasible) begin
        $display("%0t infeasible expected %b actual %b", $time,
                 exp_r.infeasible, got.infeasible);
        fails++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  mcfs_edge_if   edge_if ();
  mcfs_result_if res_if ();

  min_cost_flow_solver_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .edge_in    (edge_if),
    .result_out (res_if),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  flow_scoreboard  sb = new();
  longint unsigned cycles = 0;
  int unsigned     burst_left = 0;
  int unsigned     items_sent = 0;
  int unsigned     stall_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("min_cost_flow_solver_core: mismatch");
      $finish;
    end
  end

  // receiver stalls in runs of random length
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else if (stall_left == 0) begin
      stall_left = $urandom_range(1, 40);
      res_if.ready <= ($urandom_range(0, 2) != 0);
    end else begin
      stall_left--;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && res_if.valid && res_if.ready) sb.check_result(res_if.payload);

  task automatic write_reg(reg_idx_e idx, logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 4'(idx) << 2;
    pwdata <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, v);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_cfg(int unsigned n, int unsigned s, int unsigned t, logic [31:0] d);
    write_reg(REG_VERTEX_COUNT, n);
    write_reg(REG_SOURCE, s);
    write_reg(REG_SINK, t);
    write_reg(REG_DEMAND, d);
  endtask

  task automatic send_edge(edge_in_t e);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        edge_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    edge_if.valid <= 1'b1;
    edge_if.payload <= e;
    do @(posedge clk_i); while (!edge_if.ready);
    sb.note_edge(e);
    items_sent++;
    @(negedge clk_i);
  endtask

  function automatic edge_in_t mk_edge(int unsigned span, bit last);
    edge_in_t e;
    bit wild;
    wild = ($urandom_range(0, 9) == 0);
    e.edge_from = wild ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, span - 1));
    e.edge_to = wild ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, span - 1));
    e.edge_capacity = ($urandom_range(0, 6) == 0) ? $urandom() : $urandom_range(0, 15);
    e.edge_cost = ($urandom_range(0, 6) == 0) ? 31'($urandom()) : 31'($urandom_range(0, 20));
    e.last_edge = last;
    return e;
  endfunction

  task automatic settle();
    edge_if.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic one_edge(bit [5:0] f, bit [5:0] t, logic [31:0] cap, logic [30:0] c);
    edge_in_t e;
    e.edge_from = f;
    e.edge_to = t;
    e.edge_capacity = cap;
    e.edge_cost = c;
    e.last_edge = 1'b1;
    send_edge(e);
    settle();
  endtask

  task automatic random_graph(int unsigned ne_force, int unsigned n_force);
    int unsigned r;
    int unsigned n;
    int unsigned span;
    int unsigned s;
    int unsigned t;
    int unsigned ne;
    logic [31:0] d;
    r = $urandom_range(0, 99);
    if (n_force != 0) n = n_force;
    else if (r < 3) n = 64;
    else if (r < 5) n = 0;
    else if (r < 7) n = $urandom_range(65, 127);
    else n = $urandom_range(2, 6);
    span = (n == 0) ? 1 : (n > 64) ? 64 : n;
    s = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, span - 1);
    t = ($urandom_range(0, 9) == 0) ? s :
        ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, span - 1);
    r = $urandom_range(0, 9);
    d = (r == 0) ? 32'd0 : (r == 1) ? $urandom() : $urandom_range(1, 30);
    set_cfg(n, s, t, d);
    if (ne_force != 0) ne = ne_force;
    else ne = (span > 8) ? $urandom_range(1, 6) : $urandom_range(1, 12);
    for (int unsigned i = 0; i < ne; i++) send_edge(mk_edge(span, i == ne - 1));
    settle();
  endtask

  initial begin
    bit table_full_done;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    edge_if.valid = 1'b0;
    edge_if.payload = '0;
    table_full_done = 0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (4) @(negedge clk_i);

    // zero demand at reset settings
    one_edge(6'd0, 6'd63, 32'd5, 31'd3);
    // saturating cost on one wide edge
    set_cfg(2, 0, 1, 32'hFFFF_FFFF);
    one_edge(6'd0, 6'd1, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
    set_cfg(64, 63, 0, 32'd7);
    one_edge(6'd63, 6'd0, 32'd7, 31'd1);
    // source equals sink
    set_cfg(4, 2, 2, 32'd9);
    one_edge(6'd1, 6'd3, 32'd0, 31'd0);
    // source outside the vertex count
    set_cfg(2, 5, 1, 32'd1);
    one_edge(6'd5, 6'd1, 32'd3, 31'd2);
    // vertex count zero and above the maximum
    set_cfg(0, 0, 0, 32'd4);
    one_edge(6'd0, 6'd0, 32'd1, 31'd1);
    set_cfg(127, 0, 63, 32'd2);
    one_edge(6'd0, 6'd63, 32'd2, 31'd5);
    // unreachable sink
    set_cfg(3, 0, 2, 32'd1);
    one_edge(6'd0, 6'd1, 32'd4, 31'd1);
    // two parallel paths joined by a cross edge, demand split
    set_cfg(4, 0, 3, 32'd6);
    send_edge('{6'd0, 6'd1, 32'd4, 31'd1, 1'b0});
    send_edge('{6'd1, 6'd3, 32'd4, 31'd1, 1'b0});
    send_edge('{6'd0, 6'd2, 32'd5, 31'd4, 1'b0});
    send_edge('{6'd2, 6'd3, 32'd5, 31'd0, 1'b0});
    send_edge('{6'd1, 6'd2, 32'd3, 31'd0, 1'b1});
    settle();

    while (items_sent < ITEM_TARGET) begin
      if (!table_full_done && items_sent > 700) begin
        table_full_done = 1;
        random_graph(MAX_EDGES + 4, 3);
      end else begin
        random_graph(0, 0);
      end
    end

    settle();
    repeat (100) @(posedge clk_i);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("min_cost_flow_solver_core: match");
    end else begin
      $display("min_cost_flow_solver_core: mismatch");
    end
    $finish;
  end
endmodule
